/* rtl/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int CMD_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_EQ  = 3'd4
  } cmd_t;

  localparam int RES_NUM_W = 32;
  localparam int RES_DEN_W = 30;

endpackage

/* rtl/rau_if.sv */
// Valid/ready channel interface carrying a generic payload.
interface rau_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rau_divider.sv */
// Restoring divider, one quotient bit per cycle, quotient and remainder out.
module rau_divider #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  dvs;
  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  always_comb begin
    shifted = {rem, quo[W-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= CW'(W);
      end else if (busy) begin
        if (trial[W]) begin
          rem <= shifted[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end else begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

  property p_start_idle;
    @(posedge clk) disable iff (rst) start |=> busy;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("start did not set busy");

  property p_cnt_bound;
    @(posedge clk) disable iff (rst) busy |-> (cnt != '0);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("counter underflow");
endmodule

/* rtl/rational_arithmetic_unit_top.sv */
// Rational arithmetic unit: sequencer, shared multiplier path and shared divider.
//
// Channels: in_ch (sink) takes command, lhs_num, lhs_den, rhs_num, rhs_den;
// out_ch (source) gives res_num, res_den, is_equal, status. A beat moves on
// valid && ready. One result per input beat.
// Sequence: the four products are formed in turn on a single shared
// multiplier, then the Euclidean gcd runs one remainder per pass through
// the shared bit-serial divider, and two more divider passes divide out
// the gcd. Equality, zero results and errors skip the gcd and go straight
// to the result beat. The divider yields one quotient bit per cycle while
// a pass is running.
// One item at a time: in_ch.ready is high only while the unit is idle,
// in the cycle after the result beat at the earliest.
// A finished result sits in the output register until taken; a stalled
// receiver simply holds the unit in that wait.
// Reset (rst, synchronous) returns the sequencer to idle with no result
// pending. There is no configuration port.
module rational_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  rau_if.sink   in_ch,
  rau_if.source out_ch
);
  import rau_pkg::*;

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;        // product width (signed)
  localparam int DW = PW + 2;        // divider width, magnitudes of sums

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_COMB, S_GSTART, S_GWAIT,
    S_QSTART, S_QWAIT, S_DSTART, S_DWAIT, S_OUT
  } state_t;

  state_t state;
  cmd_t   cmd;
  logic signed [OW-1:0] n1, n2;
  logic [OW-2:0]        d1, d2;
  logic signed [PW-1:0] p0, p1, p2, p3;   // n1*d2, n2*d1, n1*n2, d1*d2
  logic signed [PW-1:0] mul_res;
  logic signed [OW:0]   ma, mb;
  logic [DW-1:0] an, ad, gx, gy, qn;
  logic          neg;
  logic          div_start, div_done;
  logic [DW-1:0] div_a, div_b, div_q, div_r;
  logic signed [DW-1:0] num_s, den_s;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_M0:    begin ma = (OW+1)'(n1); mb = (OW+1)'({1'b0, d2}); end
      S_M1:    begin ma = (OW+1)'(n2); mb = (OW+1)'({1'b0, d1}); end
      S_M2:    begin ma = (OW+1)'(n1); mb = (OW+1)'(n2); end
      S_M3:    begin ma = (OW+1)'({1'b0, d1}); mb = (OW+1)'({1'b0, d2}); end
      default: begin ma = '0; mb = '0; end
    endcase
    mul_res = PW'(ma * mb);
  end

  always_comb begin
    num_s = '0;
    den_s = DW'(p3);
    case (cmd)
      CMD_ADD: num_s = DW'(p0) + DW'(p1);
      CMD_SUB: num_s = DW'(p0) - DW'(p1);
      CMD_MUL: num_s = DW'(p2);
      CMD_DIV: begin num_s = DW'(p0); den_s = DW'(p1); end
      default: num_s = '0;
    endcase
  end

  always_comb begin
    div_a = gx;
    div_b = gy;
    if (state == S_QSTART) begin
      div_a = an;
      div_b = gx;
    end else if (state == S_DSTART) begin
      div_a = ad;
      div_b = gx;
    end
  end
  assign div_start = (state == S_GSTART) || (state == S_QSTART) || (state == S_DSTART);

  rau_divider #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd   <= cmd_t'(in_ch.data.command);
            n1    <= in_ch.data.lhs_num;
            d1    <= in_ch.data.lhs_den;
            n2    <= in_ch.data.rhs_num;
            d2    <= in_ch.data.rhs_den;
            state <= S_M0;
          end
        end
        S_M0: begin p0 <= mul_res; state <= S_M1; end
        S_M1: begin p1 <= mul_res; state <= S_M2; end
        S_M2: begin p2 <= mul_res; state <= S_M3; end
        S_M3: begin p3 <= mul_res; state <= S_COMB; end
        S_COMB: begin
          out_ch.data.is_equal <= 1'b0;
          out_ch.data.status   <= 1'b0;
          out_ch.data.res_num  <= '0;
          out_ch.data.res_den  <= '0;
          state                <= S_OUT;
          if (cmd == CMD_EQ) begin
            out_ch.data.is_equal <= (p0 == p1);
          end else if (cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_MUL ||
                       cmd == CMD_DIV) begin
            if (den_s == '0) begin
              out_ch.data.status <= 1'b1;
            end else if (num_s == '0) begin
              out_ch.data.res_den <= RES_DEN_W'(1);
            end else begin
              neg   <= num_s[DW-1] ^ den_s[DW-1];
              an    <= num_s[DW-1] ? DW'(-num_s) : DW'(num_s);
              ad    <= den_s[DW-1] ? DW'(-den_s) : DW'(den_s);
              gx    <= num_s[DW-1] ? DW'(-num_s) : DW'(num_s);
              gy    <= den_s[DW-1] ? DW'(-den_s) : DW'(den_s);
              state <= S_GSTART;
            end
          end
        end
        S_GSTART: state <= S_GWAIT;
        S_GWAIT: begin
          if (div_done) begin
            gx <= gy;
            gy <= div_r;
            state <= (div_r == '0) ? S_QSTART : S_GSTART;
          end
        end
        S_QSTART: state <= S_QWAIT;
        S_QWAIT: begin
          if (div_done) begin
            qn    <= div_q;
            state <= S_DSTART;
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            out_ch.data.res_num <= neg ? RES_NUM_W'(-qn) : RES_NUM_W'(qn);
            out_ch.data.res_den <= RES_DEN_W'(div_q);
            state               <= S_OUT;
          end
        end
        S_OUT: begin
          out_ch.valid <= 1'b1;
          if (out_ch.valid && out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_ready_idle;
    @(posedge clk) disable iff (rst) out_ch.valid |-> !in_ch.ready;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("input taken while result pending");

  property p_accept_starts;
    @(posedge clk) disable iff (rst) (in_ch.valid && in_ch.ready) |=> state == S_M0;
  endproperty
  a_accept_starts: assert property (p_accept_starts) else $error("accept did not start item");

  property p_err_clean;
    @(posedge clk) disable iff (rst)
      (out_ch.valid && out_ch.data.status) |-> (out_ch.data.res_den == '0);
  endproperty
  a_err_clean: assert property (p_err_clean) else $error("error result with denominator");

  property p_eq_only_eq;
    @(posedge clk) disable iff (rst)
      (out_ch.valid && out_ch.data.is_equal) |-> (cmd == CMD_EQ);
  endproperty
  a_eq_only_eq: assert property (p_eq_only_eq) else $error("is_equal outside equality test");
endmodule
